// ===== hw/rtl/swlr_pkg.sv =====
package swlr_pkg;

   localparam int LAP_SLOTS = 10;
   localparam int CNT_W = $clog2(LAP_SLOTS + 1);

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_START_STOP = 2'd1,
      OP_CLEAR      = 2'd2,
      OP_LAP        = 2'd3
   } op_type;

   localparam logic [1:0] RUN_IDLE    = 2'd0;
   localparam logic [1:0] RUN_RUNNING = 2'd1;
   localparam logic [1:0] RUN_STOPPED = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] lap_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  run_state;
      logic [31:0] elapsed_ms;
      logic [3:0]  lap_count;
      logic        lap_valid;
      logic [31:0] lap_split_ms;
      logic [31:0] lap_total_ms;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] split;
      logic [31:0] total;
   } lap_type;

endpackage

// ===== hw/rtl/swlr_lap_cell.sv =====
module swlr_lap_cell (
   input  logic             clock,
   input  logic             shift_en,
   input  swlr_pkg::lap_type lap_in,
   output swlr_pkg::lap_type lap_next,
   output swlr_pkg::lap_type lap_ff
);

   swlr_pkg::lap_type lap_in_w;

   always_comb begin
      lap_in_w = shift_en ? lap_in : lap_ff;
      lap_next = lap_in_w;
   end

   always_ff @(posedge clock) begin
      lap_ff <= lap_in_w;
   end

endmodule

// ===== hw/rtl/swlr_rsp_queue.sv =====
module swlr_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  swlr_pkg::rsp_word_type  push_word,
   output logic                    full,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output swlr_pkg::rsp_word_type  rsp_word
);

   swlr_pkg::rsp_word_type head_ff, head_in;
   swlr_pkg::rsp_word_type tail_ff, tail_in;
   logic                   head_vld_ff, head_vld_in;
   logic                   tail_vld_ff, tail_vld_in;
   logic                   pop;

   always_comb begin
      pop         = head_vld_ff & ~rsp_stall;
      head_in     = head_ff;
      tail_in     = tail_ff;
      head_vld_in = head_vld_ff;
      tail_vld_in = tail_vld_ff;
      if (pop) begin
         if (tail_vld_ff) begin
            head_in     = tail_ff;
            tail_in     = push_word;
            tail_vld_in = push;
         end else begin
            head_in     = push_word;
            head_vld_in = push;
         end
      end else if (push) begin
         if (head_vld_ff) begin
            tail_in     = push_word;
            tail_vld_in = 1'b1;
         end else begin
            head_in     = push_word;
            head_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         head_vld_ff <= 1'b0;
         tail_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         tail_vld_ff <= tail_vld_in;
      end
   end

   assign full      = tail_vld_ff;
   assign rsp_valid = head_vld_ff;
   assign rsp_word  = head_ff;

endmodule

// ===== hw/rtl/stopwatch_lap_recorder.sv =====
// Stopwatch with lap memory. Each accepted event word (tick, start/stop, clear, lap) returns
// exactly one status word, registered into the output queue, reporting the mode, elapsed count,
// number of stored laps and the lap at the requested oldest-first index. A new event can be
// taken every cycle while req_stall is low: all state updates in the cycle the event is
// accepted, and the lap store is a row of cells that shift one place toward the oldest end on
// each recorded lap, newest in the first cell. A two-word output queue holds results while the
// result side stalls; req_stall rises only when both queue entries are occupied.
module stopwatch_lap_recorder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  swlr_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output swlr_pkg::rsp_word_type rsp_word
);

   localparam int CNT_W = swlr_pkg::CNT_W;
   localparam int EXT_W = CNT_W + 4;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'b001,
      MODE_RUNNING = 3'b010,
      MODE_STOPPED = 3'b100
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [31:0]            elapsed_ff, elapsed_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   accept, full, lap_take;
   logic [31:0]            newest_total;
   logic [EXT_W-1:0]       idx_ext;
   logic [CNT_W-1:0]       pos;
   logic                   lap_valid;
   swlr_pkg::lap_type      new_lap, sel_lap;
   swlr_pkg::lap_type      cell_ff   [swlr_pkg::LAP_SLOTS];
   swlr_pkg::lap_type      cell_next [swlr_pkg::LAP_SLOTS];
   swlr_pkg::lap_type      cell_src  [swlr_pkg::LAP_SLOTS];
   swlr_pkg::rsp_word_type result;
   logic [1:0]             run_code;

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   always_comb begin
      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      count_in   = count_ff;
      lap_take   = 1'b0;
      if (accept) begin
         case (swlr_pkg::op_type'(req_word.op))
            swlr_pkg::OP_TICK: begin
               if (mode_ff == MODE_RUNNING) begin
                  elapsed_in = elapsed_ff + 32'd1;
               end
            end
            swlr_pkg::OP_START_STOP: begin
               mode_in = (mode_ff == MODE_RUNNING) ? MODE_STOPPED : MODE_RUNNING;
            end
            swlr_pkg::OP_CLEAR: begin
               mode_in    = MODE_IDLE;
               elapsed_in = 32'd0;
               count_in   = '0;
            end
            default: begin
               if (mode_ff == MODE_RUNNING) begin
                  lap_take = 1'b1;
                  if (count_ff != CNT_W'(swlr_pkg::LAP_SLOTS)) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         endcase
      end
   end

   assign newest_total  = (count_ff != '0) ? cell_ff[0].total : 32'd0;
   assign new_lap.split = elapsed_ff - newest_total;
   assign new_lap.total = elapsed_ff;

   genvar k;
   generate
      for (k = 0; k < swlr_pkg::LAP_SLOTS; k++) begin : g_cell
         if (k == 0) begin : g_head
            assign cell_src[k] = new_lap;
         end else begin : g_body
            assign cell_src[k] = cell_ff[k-1];
         end
         swlr_lap_cell u_cell (
            .clock    (clock),
            .shift_en (lap_take),
            .lap_in   (cell_src[k]),
            .lap_next (cell_next[k]),
            .lap_ff   (cell_ff[k])
         );
      end
   endgenerate

   // oldest-first index maps to cell count-1-index
   always_comb begin
      idx_ext   = EXT_W'(req_word.lap_index);
      lap_valid = idx_ext < EXT_W'(count_in);
      pos       = count_in - CNT_W'(1) - idx_ext[CNT_W-1:0];
      sel_lap   = '0;
      for (int i = 0; i < swlr_pkg::LAP_SLOTS; i++) begin
         if (lap_valid && (pos == CNT_W'(i))) begin
            sel_lap = cell_next[i];
         end
      end
   end

   always_comb begin
      unique case (mode_in)
         MODE_RUNNING: run_code = swlr_pkg::RUN_RUNNING;
         MODE_STOPPED: run_code = swlr_pkg::RUN_STOPPED;
         default:      run_code = swlr_pkg::RUN_IDLE;
      endcase
      result.run_state    = run_code;
      result.elapsed_ms   = elapsed_in;
      result.lap_count    = 4'(count_in);
      result.lap_valid    = lap_valid;
      result.lap_split_ms = sel_lap.split;
      result.lap_total_ms = sel_lap.total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         elapsed_ff <= 32'd0;
         count_ff   <= '0;
      end else begin
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         count_ff   <= count_in;
      end
   end

   swlr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_word (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(swlr_pkg::LAP_SLOTS))
      else $error("lap count beyond store size");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.lap_valid) |->
         (rsp_word.lap_split_ms == 32'd0 && rsp_word.lap_total_ms == 32'd0))
      else $error("invalid lap reports nonzero data");

   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.op == swlr_pkg::OP_TICK && mode_ff == MODE_RUNNING) |=>
         elapsed_ff == $past(elapsed_ff) + 32'd1)
      else $error("running tick did not advance elapsed count");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.op == swlr_pkg::OP_CLEAR) |=>
         (mode_ff == MODE_IDLE && count_ff == '0 && elapsed_ff == 32'd0))
      else $error("clear did not return to idle");

endmodule
